### rtl/itcg_pkg.sv
// Shared types, constants and lookup functions for the intensity-to-glyph cell encoder.
`default_nettype none

package itcg_pkg;

    // Port width of the intensity field and the number of its bits that are used.
    localparam int INTENSITY_W    = 8;
    localparam int INTENSITY_BITS = 8;
    localparam int ROM_DEPTH      = 1 << INTENSITY_BITS;
    localparam int FULL_SCALE     = ROM_DEPTH - 1;

    localparam int GLYPH_W   = 16;
    localparam int COLOR_W   = 8;
    localparam int ATTR_W    = 10;
    localparam int RAMP_LEN  = 13;
    localparam int LEVEL_MAX = 51;
    localparam int LEVEL_DEN = 52;
    localparam int GAMMA_NUM = 19;   // gamma 1.9 as 19/10
    localparam int GAMMA_DEN = 10;
    localparam int TEXT_IDX_MIN = 8;

    // Wide enough for 52^10 * x^19 and 51^10 * M^19.
    localparam int BIG_W = GAMMA_NUM * INTENSITY_BITS + 64;

    // Wide-character flags, bits 9:8 of the cell attribute.
    localparam logic [1:0] WFLAG_NONE  = 2'b00;
    localparam logic [1:0] WFLAG_LEAD  = 2'b01;
    localparam logic [1:0] WFLAG_TRAIL = 2'b10;

    typedef struct packed {
        logic [1:0] band;
        logic [3:0] idx;     // already mirrored on odd bands
    } t_gamma_entry;

    typedef t_gamma_entry [ROM_DEPTH-1:0] t_gamma_rom;

    typedef struct packed {
        logic [GLYPH_W-1:0] glyph;
        logic [COLOR_W-1:0] attr;
    } t_cell;

    typedef struct packed {
        logic               valid;
        logic [GLYPH_W-1:0] text_code;
        logic               row_end;
    } t_s1_item;

    // Exact gamma test: level is the largest L with 52^10 x^19 >= L^10 M^19.
    function automatic t_gamma_rom build_gamma_rom();
        t_gamma_rom       rom;
        logic [BIG_W-1:0] lhs;
        logic [BIG_W-1:0] scale;
        logic [BIG_W-1:0] rhs;
        int               level;
        int               band;
        int               idx;
        rom   = '0;
        scale = BIG_W'(1);
        for (int k = 0; k < GAMMA_NUM; k++) begin
            scale = scale * BIG_W'(FULL_SCALE);
        end
        for (int x = 0; x < ROM_DEPTH; x++) begin
            lhs = BIG_W'(1);
            for (int k = 0; k < GAMMA_NUM; k++) begin
                lhs = lhs * BIG_W'(x);
            end
            for (int k = 0; k < GAMMA_DEN; k++) begin
                lhs = lhs * BIG_W'(LEVEL_DEN);
            end
            level = 0;
            for (int lv = LEVEL_MAX; lv >= 1; lv--) begin
                if (level == 0) begin
                    rhs = scale;
                    for (int k = 0; k < GAMMA_DEN; k++) begin
                        rhs = rhs * BIG_W'(lv);
                    end
                    if (lhs >= rhs) begin
                        level = lv;
                    end
                end
            end
            band = level / RAMP_LEN;
            idx  = level % RAMP_LEN;
            if ((band % 2) == 1) begin
                idx = RAMP_LEN - 1 - idx;
            end
            rom[x].band = 2'(band);
            rom[x].idx  = 4'(idx);
        end
        return rom;
    endfunction

    localparam t_gamma_rom GAMMA_ROM = build_gamma_rom();

    // Ramp " .,:x!|X#%@$M", darkest first.
    function automatic logic [GLYPH_W-1:0] ramp_glyph(input logic [3:0] idx);
        logic [GLYPH_W-1:0] g;
        case (idx)
            4'd0:    g = 16'h0020;
            4'd1:    g = 16'h002E;
            4'd2:    g = 16'h002C;
            4'd3:    g = 16'h003A;
            4'd4:    g = 16'h0078;
            4'd5:    g = 16'h0021;
            4'd6:    g = 16'h007C;
            4'd7:    g = 16'h0058;
            4'd8:    g = 16'h0023;
            4'd9:    g = 16'h0025;
            4'd10:   g = 16'h0040;
            4'd11:   g = 16'h0024;
            4'd12:   g = 16'h004D;
            default: g = 16'h0020;
        endcase
        return g;
    endfunction

    function automatic logic [COLOR_W-1:0] plain_attr(input logic [1:0] band);
        logic [COLOR_W-1:0] a;
        case (band)
            2'd0:    a = 8'h08;
            2'd1:    a = 8'h80;
            2'd2:    a = 8'h84;
            2'd3:    a = 8'h48;
            default: a = 8'h08;
        endcase
        return a;
    endfunction

    function automatic logic [COLOR_W-1:0] text_attr(input logic [1:0] band);
        logic [COLOR_W-1:0] a;
        case (band)
            2'd0:    a = 8'h80;
            2'd1:    a = 8'h08;
            2'd2:    a = 8'h48;
            2'd3:    a = 8'h84;
            default: a = 8'h80;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

### rtl/itcg_lookup.sv
// Gamma ROM, ramp glyph and attribute selection for one cell.
`default_nettype none

module itcg_lookup (
    input  wire logic [itcg_pkg::INTENSITY_W-1:0] i_intensity,
    input  wire logic [itcg_pkg::GLYPH_W-1:0]     i_text_code,
    output itcg_pkg::t_cell                       o_cell
);

    logic [itcg_pkg::INTENSITY_BITS-1:0] w_x;
    itcg_pkg::t_gamma_entry              w_ent;
    logic                                w_has_text;

    assign w_x        = itcg_pkg::INTENSITY_BITS'(i_intensity);
    assign w_ent      = itcg_pkg::GAMMA_ROM[w_x];
    assign w_has_text = |i_text_code;

    always_comb begin
        o_cell.glyph = itcg_pkg::ramp_glyph(w_ent.idx);
        o_cell.attr  = itcg_pkg::plain_attr(w_ent.band);
        if (w_has_text) begin
            o_cell.glyph = i_text_code;
            if (w_ent.idx >= 4'(itcg_pkg::TEXT_IDX_MIN)) begin
                o_cell.attr = itcg_pkg::text_attr(w_ent.band);
            end
        end
    end

endmodule

`default_nettype wire

### rtl/itcg_out_stage.sv
// Result register with wide-character hold and lead/trail split.
`default_nettype none

module itcg_out_stage (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire itcg_pkg::t_s1_item            i_item,
    input  wire itcg_pkg::t_cell               i_cell,
    output logic                               o_take,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [itcg_pkg::GLYPH_W-1:0]       o_glyph,
    output logic [itcg_pkg::ATTR_W-1:0]        o_cell_attr,
    output logic                               o_row_done
);

    logic                            r_out_valid, n_out_valid;
    logic [itcg_pkg::GLYPH_W-1:0]    r_glyph, n_glyph;
    logic [itcg_pkg::ATTR_W-1:0]     r_attr, n_attr;
    logic                            r_done, n_done;
    logic                            r_wide_pending, n_wide_pending;
    logic                            r_trail_due, n_trail_due;
    logic                            r_trail_rend, n_trail_rend;
    logic [itcg_pkg::GLYPH_W-1:0]    r_held_glyph, n_held_glyph;
    logic [itcg_pkg::COLOR_W-1:0]    r_held_attr, n_held_attr;
    logic                            w_out_free;
    logic                            w_wide_new;

    always_comb begin
        w_out_free = !r_out_valid || !i_out_stall;
        w_wide_new = (|i_item.text_code[15:8]) && !i_item.row_end;
        o_take     = i_item.valid && !r_trail_due &&
                     (w_out_free || (!r_wide_pending && w_wide_new));

        n_out_valid    = r_out_valid;
        n_glyph        = r_glyph;
        n_attr         = r_attr;
        n_done         = r_done;
        n_wide_pending = r_wide_pending;
        n_trail_due    = r_trail_due;
        n_trail_rend   = r_trail_rend;
        n_held_glyph   = r_held_glyph;
        n_held_attr    = r_held_attr;

        if (r_trail_due) begin
            if (w_out_free) begin
                n_out_valid = 1'b1;
                n_glyph     = r_held_glyph;
                n_attr      = {itcg_pkg::WFLAG_TRAIL, r_held_attr};
                n_done      = r_trail_rend;
                n_trail_due = 1'b0;
            end
        end else if (o_take) begin
            if (r_wide_pending) begin
                // covered cell: its fields are dropped except row_end
                n_out_valid    = 1'b1;
                n_glyph        = r_held_glyph;
                n_attr         = {itcg_pkg::WFLAG_LEAD, r_held_attr};
                n_done         = 1'b0;
                n_wide_pending = 1'b0;
                n_trail_due    = 1'b1;
                n_trail_rend   = i_item.row_end;
            end else if (w_wide_new) begin
                n_wide_pending = 1'b1;
                n_held_glyph   = i_cell.glyph;
                n_held_attr    = i_cell.attr;
                if (w_out_free) begin
                    n_out_valid = 1'b0;
                end
            end else begin
                n_out_valid = 1'b1;
                n_glyph     = i_cell.glyph;
                n_attr      = {itcg_pkg::WFLAG_NONE, i_cell.attr};
                n_done      = i_item.row_end;
            end
        end else if (w_out_free) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_wide_pending <= 1'b0;
            r_trail_due    <= 1'b0;
        end else begin
            r_out_valid    <= n_out_valid;
            r_wide_pending <= n_wide_pending;
            r_trail_due    <= n_trail_due;
        end
    end

    always_ff @(posedge i_clk) begin
        r_glyph      <= n_glyph;
        r_attr       <= n_attr;
        r_done       <= n_done;
        r_trail_rend <= n_trail_rend;
        r_held_glyph <= n_held_glyph;
        r_held_attr  <= n_held_attr;
    end

    assign o_out_valid = r_out_valid;
    assign o_glyph     = r_glyph;
    assign o_cell_attr = r_attr;
    assign o_row_done  = r_done;

    // a pending trail means the lead already left the hold
    a_trail_not_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_trail_due |-> !r_wide_pending)
        else $error("trail due while wide still pending");

    a_trail_has_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_trail_due |-> r_out_valid)
        else $error("trail due with empty result register");

    a_lead_then_trail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_attr[8]) |-> r_trail_due)
        else $error("lead half shown without its trail queued");

    a_trail_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_trail_due) |-> (r_out_valid && r_attr[9]))
        else $error("trail half not loaded when trail cleared");

endmodule

`default_nettype wire

### rtl/intensity_to_console_glyph.sv
// Top level of the intensity-to-console-glyph cell encoder.
`default_nettype none

// Converts a stream of screen cells (8-bit intensity, optional 16-bit text code,
// row_end marker) into console cells: a 16-bit glyph and a 10-bit attribute.
// Intensity goes through a gamma 1.9 ROM to a level 0..51; level mod 13 picks a
// ramp glyph (mirrored on odd bands) and level div 13 picks one of four color
// bytes. Nonzero text replaces the glyph and, for ramp index 8 or more, uses the
// text color set. A text code above 255 is a wide character: that word yields no
// result by itself; the following word (only its row_end is used) yields two
// results, the held cell with bit 8 (leading half) and its copy with bit 9
// (trailing half), the copy carrying that word's row_end. A wide character on the
// last cell of a row comes out as one plain cell without flags.
// Timing: one word per clock in and out unless output stall or a wide char holds
// it; input register, then result register, with the gamma ROM and glyph/color
// lookup between them. The word after a wide character fills the result register
// for both halves, so input stalls while the trail is due. An output-stalled
// result does not block input for one further word; the input register buffers it.
// No clearing pass after reset; the block takes words right away.
module intensity_to_console_glyph (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [itcg_pkg::INTENSITY_W-1:0]  i_intensity,
    input  wire logic [itcg_pkg::GLYPH_W-1:0]      i_text_code,
    input  wire logic                              i_row_end,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [itcg_pkg::GLYPH_W-1:0]           o_glyph,
    output logic [itcg_pkg::ATTR_W-1:0]            o_cell_attr,
    output logic                                   o_row_done
);

    // input register stage
    logic                              r_s1_valid;
    logic [itcg_pkg::INTENSITY_W-1:0]  r_s1_intensity;
    logic [itcg_pkg::GLYPH_W-1:0]      r_s1_text;
    logic                              r_s1_row_end;
    logic                              n_s1_valid;

    itcg_pkg::t_s1_item                w_item;
    itcg_pkg::t_cell                   w_cell;
    logic                              w_take;

    // stage 1 may refill in the same clock that its word moves on
    assign o_in_stall = r_s1_valid && !w_take;
    assign n_s1_valid = o_in_stall ? r_s1_valid : i_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1_intensity <= i_intensity;
            r_s1_text      <= i_text_code;
            r_s1_row_end   <= i_row_end;
        end
    end

    assign w_item.valid     = r_s1_valid;
    assign w_item.text_code = r_s1_text;
    assign w_item.row_end   = r_s1_row_end;

    itcg_lookup u_lookup (
        .i_intensity (r_s1_intensity),
        .i_text_code (r_s1_text),
        .o_cell      (w_cell)
    );

    itcg_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_item),
        .i_cell      (w_cell),
        .o_take      (w_take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_glyph     (o_glyph),
        .o_cell_attr (o_cell_attr),
        .o_row_done  (o_row_done)
    );

endmodule

`default_nettype wire
